@@ sv/rro_pkg.sv @@
`timescale 1ns / 1ps

package rro_pkg;

    // Angle in units of 1/64 degree
    localparam int ANGLE_W       = 15;
    localparam int ANGLE_REM_W   = 13;
    localparam int ANGLE_FULL    = 23040;
    localparam int ANGLE_QUARTER = 5760;
    localparam int ANGLE_HALF    = 11520;
    localparam int ANGLE_3QUART  = 17280;

    // Sine magnitude in Q1.14, full scale 16384
    localparam int SIN_MAG_W = 15;
    localparam int Q14_SHIFT = 14;
    localparam int Q14_HALF  = 8192;

    // Series constants for the quarter-wave table, Q30
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;

    // Corners carry three guard bits over the input coordinate
    localparam int CORNER_EXTRA = 3;

    // Cross products below one square pixel count as colinear
    localparam int COLIN_LIM = 65536;

    // Pipeline depth and result bus width
    localparam int STAGES      = 9;
    localparam int OUT_TDATA_W = 8;

    typedef struct packed {
        logic neg;
        logic zero;
        logic near_zero;
    } t_xcls;

    typedef enum logic [1:0] {
        ORIENT_COLIN,
        ORIENT_CW,
        ORIENT_CCW
    } t_orient;

    // Index [s][i*4+j]: s = rectangle that owns the edge or the point
    typedef struct packed {
        logic [1:0][15:0] box;
        logic [1:0][15:0] cr;
        logic [1:0][15:0] pos;
    } t_geo_flags;

endpackage

@@ sv/rro_trig.sv @@
`timescale 1ns / 1ps

module rro_trig #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic [2:0]                     i_en,
    input  logic [rro_pkg::ANGLE_W-1:0]    i_angle,
    output logic [rro_pkg::SIN_MAG_W-1:0]  o_sin_mag,
    output logic                           o_sin_neg,
    output logic [rro_pkg::SIN_MAG_W-1:0]  o_cos_mag,
    output logic                           o_cos_neg
);
    import rro_pkg::*;

    localparam int IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int RECIP_SHIFT = 32;
    localparam int PROD_W      = ANGLE_REM_W + RECIP_SHIFT;
    localparam longint RECIP =
        ((longint'(SINE_TABLE_DEPTH) <<< RECIP_SHIFT) + ANGLE_QUARTER - 1) / ANGLE_QUARTER;
    localparam logic [RECIP_SHIFT-1:0] RECIP_V = RECIP_SHIFT'(RECIP);
    localparam longint SERIES_DIV [1:10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

    typedef logic [SIN_MAG_W-1:0] t_rom [SINE_TABLE_DEPTH+1];

    // Quarter-wave table by Taylor series, worked out at elaboration
    function automatic t_rom f_build_rom();
        t_rom   rom;
        longint x;
        longint sum;
        longint term;
        longint v;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = HALF_PI_Q30 * longint'(i) / SINE_TABLE_DEPTH;
            sum  = x;
            term = x;
            for (int k = 1; k <= 10; k++) begin
                term = term * x / ONE_Q30;
                term = term * x / ONE_Q30;
                term = term / SERIES_DIV[k];
                term = -term;
                sum  = sum + term;
            end
            v = (sum < 0) ? 64'sd0 : (sum + 64'sd32768) / 64'sd65536;
            if (v > 64'sd16384) v = 64'sd16384;
            rom[i] = SIN_MAG_W'(v);
        end
        return rom;
    endfunction

    localparam t_rom SIN_ROM = f_build_rom();

    // Split an angle into quadrant and remainder
    function automatic logic [ANGLE_REM_W+1:0] f_quad(input logic [ANGLE_W-1:0] a);
        logic [1:0]         q;
        logic [ANGLE_W-1:0] base;
        if (a >= ANGLE_W'(ANGLE_3QUART)) begin
            q    = 2'd3;
            base = ANGLE_W'(ANGLE_3QUART);
        end else if (a >= ANGLE_W'(ANGLE_HALF)) begin
            q    = 2'd2;
            base = ANGLE_W'(ANGLE_HALF);
        end else if (a >= ANGLE_W'(ANGLE_QUARTER)) begin
            q    = 2'd1;
            base = ANGLE_W'(ANGLE_QUARTER);
        end else begin
            q    = 2'd0;
            base = '0;
        end
        return {q, ANGLE_REM_W'(a - base)};
    endfunction

    // Table index from remainder by reciprocal multiply, mirrored in odd quadrants
    function automatic logic [IDX_W-1:0] f_index(input logic [ANGLE_REM_W-1:0] r,
                                                 input logic odd);
        logic [PROD_W-1:0] prod;
        logic [IDX_W-1:0]  idx;
        prod = PROD_W'(r) * PROD_W'(RECIP_V);
        idx  = IDX_W'(prod[PROD_W-1:RECIP_SHIFT]);
        return odd ? IDX_W'(SINE_TABLE_DEPTH) - idx : idx;
    endfunction

    logic [ANGLE_W-1:0]     w_a_red;
    logic [ANGLE_W-1:0]     w_a_sum;
    logic [ANGLE_W-1:0]     w_a_cos;
    logic [ANGLE_REM_W+1:0] w_qs;
    logic [ANGLE_REM_W+1:0] w_qc;

    logic [1:0]             r_q_s;
    logic [1:0]             r_q_c;
    logic [ANGLE_REM_W-1:0] r_r_s;
    logic [ANGLE_REM_W-1:0] r_r_c;
    logic [IDX_W-1:0]       r_idx_s;
    logic [IDX_W-1:0]       r_idx_c;
    logic                   r_neg_s;
    logic                   r_neg_c;
    logic [SIN_MAG_W-1:0]   r_sin_mag;
    logic [SIN_MAG_W-1:0]   r_cos_mag;
    logic                   r_sin_neg;
    logic                   r_cos_neg;

    // Reduce the angle and form the cosine angle a quarter turn on
    always_comb begin
        w_a_red = (i_angle >= ANGLE_W'(ANGLE_FULL)) ? i_angle - ANGLE_W'(ANGLE_FULL) : i_angle;
        w_a_sum = w_a_red + ANGLE_W'(ANGLE_QUARTER);
        w_a_cos = (w_a_sum >= ANGLE_W'(ANGLE_FULL)) ? w_a_sum - ANGLE_W'(ANGLE_FULL) : w_a_sum;
        w_qs    = f_quad(w_a_red);
        w_qc    = f_quad(w_a_cos);
    end

    always_ff @(posedge i_clk) begin
        // Quadrant and remainder
        if (i_en[0]) begin
            r_q_s <= w_qs[ANGLE_REM_W+1:ANGLE_REM_W];
            r_r_s <= w_qs[ANGLE_REM_W-1:0];
            r_q_c <= w_qc[ANGLE_REM_W+1:ANGLE_REM_W];
            r_r_c <= w_qc[ANGLE_REM_W-1:0];
        end
        // Table index and sign
        if (i_en[1]) begin
            r_idx_s <= f_index(r_r_s, r_q_s[0]);
            r_idx_c <= f_index(r_r_c, r_q_c[0]);
            r_neg_s <= r_q_s[1];
            r_neg_c <= r_q_c[1];
        end
        // Registered table read
        if (i_en[2]) begin
            r_sin_mag <= SIN_ROM[r_idx_s];
            r_cos_mag <= SIN_ROM[r_idx_c];
            r_sin_neg <= r_neg_s;
            r_cos_neg <= r_neg_c;
        end
    end

    assign o_sin_mag = r_sin_mag;
    assign o_sin_neg = r_sin_neg;
    assign o_cos_mag = r_cos_mag;
    assign o_cos_neg = r_cos_neg;

endmodule

@@ sv/rro_corner.sv @@
`timescale 1ns / 1ps

module rro_corner #(
    parameter int COORD_WIDTH      = 24,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic [4:0]                  i_en,
    input  logic signed [COORD_WIDTH-1:0] i_left,
    input  logic signed [COORD_WIDTH-1:0] i_top,
    input  logic [COORD_WIDTH-2:0]      i_width,
    input  logic [COORD_WIDTH-2:0]      i_height,
    input  logic [rro_pkg::ANGLE_W-1:0] i_angle,
    output logic signed [COORD_WIDTH+rro_pkg::CORNER_EXTRA-1:0] o_x [4],
    output logic signed [COORD_WIDTH+rro_pkg::CORNER_EXTRA-1:0] o_y [4]
);
    import rro_pkg::*;

    localparam int CW   = COORD_WIDTH + CORNER_EXTRA;
    localparam int PP_W = COORD_WIDTH - 1 + SIN_MAG_W;
    localparam int SV_W = PP_W + 2;

    // Apply sign to a size product and round Q22 to Q8
    function automatic logic signed [SV_W-1:0] f_round(input logic [PP_W-1:0] p,
                                                       input logic neg);
        logic signed [SV_W-1:0] v;
        v = signed'({2'b00, p});
        if (neg) v = -v;
        v = v + SV_W'(Q14_HALF);
        return v >>> Q14_SHIFT;
    endfunction

    logic [SIN_MAG_W-1:0] w_sin_mag;
    logic [SIN_MAG_W-1:0] w_cos_mag;
    logic                 w_sin_neg;
    logic                 w_cos_neg;

    logic signed [COORD_WIDTH-1:0] r_left [3];
    logic signed [COORD_WIDTH-1:0] r_top  [3];
    logic [COORD_WIDTH-2:0]        r_wid  [3];
    logic [COORD_WIDTH-2:0]        r_hgt  [3];

    logic signed [COORD_WIDTH-1:0] r_left_p;
    logic signed [COORD_WIDTH-1:0] r_top_p;
    logic [PP_W-1:0]               r_wc;
    logic [PP_W-1:0]               r_ws;
    logic [PP_W-1:0]               r_hc;
    logic [PP_W-1:0]               r_hs;
    logic                          r_sneg;
    logic                          r_cneg;

    logic signed [SV_W-1:0] w_wc;
    logic signed [SV_W-1:0] w_ws;
    logic signed [SV_W-1:0] w_hc;
    logic signed [SV_W-1:0] w_hs;
    logic signed [SV_W-1:0] w_l;
    logic signed [SV_W-1:0] w_t;

    logic signed [CW-1:0] r_x [4];
    logic signed [CW-1:0] r_y [4];

    rro_trig #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_trig (
        .i_clk    (i_clk),
        .i_en     (i_en[2:0]),
        .i_angle  (i_angle),
        .o_sin_mag(w_sin_mag),
        .o_sin_neg(w_sin_neg),
        .o_cos_mag(w_cos_mag),
        .o_cos_neg(w_cos_neg)
    );

    // Hold the geometry level with the trig stages
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_left[0] <= i_left;
            r_top[0]  <= i_top;
            r_wid[0]  <= i_width;
            r_hgt[0]  <= i_height;
        end
        for (int k = 1; k < 3; k++) begin
            if (i_en[k]) begin
                r_left[k] <= r_left[k-1];
                r_top[k]  <= r_top[k-1];
                r_wid[k]  <= r_wid[k-1];
                r_hgt[k]  <= r_hgt[k-1];
            end
        end
    end

    // Size times sine and cosine magnitude
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_wc     <= PP_W'(r_wid[2]) * PP_W'(w_cos_mag);
            r_ws     <= PP_W'(r_wid[2]) * PP_W'(w_sin_mag);
            r_hc     <= PP_W'(r_hgt[2]) * PP_W'(w_cos_mag);
            r_hs     <= PP_W'(r_hgt[2]) * PP_W'(w_sin_mag);
            r_sneg   <= w_sin_neg;
            r_cneg   <= w_cos_neg;
            r_left_p <= r_left[2];
            r_top_p  <= r_top[2];
        end
    end

    always_comb begin
        w_wc = f_round(r_wc, r_cneg);
        w_ws = f_round(r_ws, r_sneg);
        w_hc = f_round(r_hc, r_cneg);
        w_hs = f_round(r_hs, r_sneg);
        w_l  = SV_W'(r_left_p);
        w_t  = SV_W'(r_top_p);
    end

    // Build the four corners
    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_x[0] <= CW'(w_l);
            r_y[0] <= CW'(w_t);
            r_x[1] <= CW'(w_l + w_wc);
            r_y[1] <= CW'(w_t + w_ws);
            r_x[2] <= CW'(w_l + w_wc - w_hs);
            r_y[2] <= CW'(w_t + w_ws + w_hc);
            r_x[3] <= CW'(w_l - w_hs);
            r_y[3] <= CW'(w_t + w_hc);
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

@@ sv/rro_xprod.sv @@
`timescale 1ns / 1ps

module rro_xprod #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                  i_clk,
    input  logic [2:0]            i_en,
    input  logic signed [COORD_WIDTH+rro_pkg::CORNER_EXTRA-1:0] i_a1,
    input  logic signed [COORD_WIDTH+rro_pkg::CORNER_EXTRA-1:0] i_a0,
    input  logic signed [COORD_WIDTH+rro_pkg::CORNER_EXTRA-1:0] i_b1,
    input  logic signed [COORD_WIDTH+rro_pkg::CORNER_EXTRA-1:0] i_b0,
    input  logic signed [COORD_WIDTH+rro_pkg::CORNER_EXTRA-1:0] i_c1,
    input  logic signed [COORD_WIDTH+rro_pkg::CORNER_EXTRA-1:0] i_c0,
    input  logic signed [COORD_WIDTH+rro_pkg::CORNER_EXTRA-1:0] i_d1,
    input  logic signed [COORD_WIDTH+rro_pkg::CORNER_EXTRA-1:0] i_d0,
    output rro_pkg::t_xcls        o_cls
);
    import rro_pkg::*;

    // (a1-a0)*(b1-b0) - (c1-c0)*(d1-d0), exact, then classified
    localparam int CW = COORD_WIDTH + CORNER_EXTRA;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int FW = PW + 1;

    logic signed [DW-1:0] r_da;
    logic signed [DW-1:0] r_db;
    logic signed [DW-1:0] r_dc;
    logic signed [DW-1:0] r_dd;
    logic signed [PW-1:0] r_p1;
    logic signed [PW-1:0] r_p2;
    logic signed [FW-1:0] w_diff;
    t_xcls                r_cls;

    assign w_diff = FW'(r_p1) - FW'(r_p2);

    always_ff @(posedge i_clk) begin
        // Differences
        if (i_en[0]) begin
            r_da <= DW'(i_a1) - DW'(i_a0);
            r_db <= DW'(i_b1) - DW'(i_b0);
            r_dc <= DW'(i_c1) - DW'(i_c0);
            r_dd <= DW'(i_d1) - DW'(i_d0);
        end
        // Products
        if (i_en[1]) begin
            r_p1 <= PW'(r_da) * PW'(r_db);
            r_p2 <= PW'(r_dc) * PW'(r_dd);
        end
        // Sign, zero and colinear band
        if (i_en[2]) begin
            r_cls.neg       <= w_diff[FW-1];
            r_cls.zero      <= (w_diff == '0);
            r_cls.near_zero <= (w_diff < FW'(COLIN_LIM)) && (w_diff > -FW'(COLIN_LIM));
        end
    end

    assign o_cls = r_cls;

endmodule

@@ sv/rotated_rect_overlap_test.sv @@
`timescale 1ns / 1ps

// Rotated rectangle overlap test.
// Input channel i_s_axis_*: one item holds two rectangles, each as corner x, corner y,
// width, height (Q15.8) and angle (1/64 degree). Output channel o_m_axis_*: one item
// per input item, bit 0 of tdata set when edges cross or a corner lies inside the other.
// Each item passes nine register stages: angle reduction, table index multiply,
// registered sine table read, size products, corner build, coordinate differences,
// cross products, cross classification, and the final edge and ray-crossing merge.
// Throughput: one item per cycle, unless a receiver stall has filled the pipeline.
// Each stage holds its own valid bit.
// When the receiver stalls, each full stage holds and empty stages still fill, so the
// block takes up to nine items before tready falls; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties the pipeline; the sine table is constant
// and needs no load after reset.
module rotated_rect_overlap_test #(
    parameter int COORD_WIDTH      = 24,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // a_left, a_top, a_width, a_height, a_angle, b_left, b_top, b_width, b_height, b_angle
    input  logic [((8*COORD_WIDTH-4+2*rro_pkg::ANGLE_W+7)/8)*8-1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // overlap
    output logic [rro_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import rro_pkg::*;

    localparam int CW     = COORD_WIDTH + CORNER_EXTRA;
    localparam int RECT_W = 4 * COORD_WIDTH - 2 + ANGLE_W;
    localparam int OFF_T  = COORD_WIDTH;
    localparam int OFF_W  = 2 * COORD_WIDTH;
    localparam int OFF_H  = 3 * COORD_WIDTH - 1;
    localparam int OFF_A  = 4 * COORD_WIDTH - 2;

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] w_en;

    logic signed [CW-1:0] w_cx [2][4];
    logic signed [CW-1:0] w_cy [2][4];

    t_xcls w_or [2][16];
    t_xcls w_in [2][16];

    t_geo_flags w_flg;
    t_geo_flags r_flg [3];

    logic w_hit;
    logic r_overlap;

    // Stage enables: a stage moves when empty or when the next one moves
    always_comb begin
        w_en[STAGES-1] = !r_v[STAGES-1] || i_m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_s_axis_tvalid;
            for (int k = 1; k < STAGES; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign o_s_axis_tready = w_en[0];

    // Corners of both rectangles
    for (genvar r = 0; r < 2; r++) begin : g_rect
        rro_corner #(
            .COORD_WIDTH     (COORD_WIDTH),
            .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
        ) u_corner (
            .i_clk   (i_clk),
            .i_en    (w_en[4:0]),
            .i_left  ($signed(i_s_axis_tdata[r*RECT_W +: COORD_WIDTH])),
            .i_top   ($signed(i_s_axis_tdata[r*RECT_W+OFF_T +: COORD_WIDTH])),
            .i_width (i_s_axis_tdata[r*RECT_W+OFF_W +: COORD_WIDTH-1]),
            .i_height(i_s_axis_tdata[r*RECT_W+OFF_H +: COORD_WIDTH-1]),
            .i_angle (i_s_axis_tdata[r*RECT_W+OFF_A +: ANGLE_W]),
            .o_x     (w_cx[r]),
            .o_y     (w_cy[r])
        );
    end

    // Orientation of each edge of one rectangle against each corner of the other,
    // and ray-crossing tests of each corner against each edge of the other
    for (genvar s = 0; s < 2; s++) begin : g_side
        for (genvar i = 0; i < 4; i++) begin : g_i
            for (genvar j = 0; j < 4; j++) begin : g_j
                rro_xprod #(
                    .COORD_WIDTH(COORD_WIDTH)
                ) u_orient (
                    .i_clk(i_clk),
                    .i_en (w_en[7:5]),
                    .i_a1 (w_cy[s][(i+1)%4]),
                    .i_a0 (w_cy[s][i]),
                    .i_b1 (w_cx[1-s][j]),
                    .i_b0 (w_cx[s][(i+1)%4]),
                    .i_c1 (w_cx[s][(i+1)%4]),
                    .i_c0 (w_cx[s][i]),
                    .i_d1 (w_cy[1-s][j]),
                    .i_d0 (w_cy[s][(i+1)%4]),
                    .o_cls(w_or[s][i*4+j])
                );
                // point = corner i of side s, edge j of the other side
                rro_xprod #(
                    .COORD_WIDTH(COORD_WIDTH)
                ) u_ray (
                    .i_clk(i_clk),
                    .i_en (w_en[7:5]),
                    .i_a1 (w_cx[1-s][(j+3)%4]),
                    .i_a0 (w_cx[1-s][j]),
                    .i_b1 (w_cy[s][i]),
                    .i_b0 (w_cy[1-s][j]),
                    .i_c1 (w_cx[s][i]),
                    .i_c0 (w_cx[1-s][j]),
                    .i_d1 (w_cy[1-s][(j+3)%4]),
                    .i_d0 (w_cy[1-s][j]),
                    .o_cls(w_in[s][i*4+j])
                );
            end
        end
    end

    // Bounding-box and ray-crossing flags, taken from the corners
    always_comb begin
        w_flg = '0;
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    w_flg.box[s][i*4+j] =
                        ((w_cx[1-s][j] <= w_cx[s][i]) || (w_cx[1-s][j] <= w_cx[s][(i+1)&3])) &&
                        ((w_cx[1-s][j] >= w_cx[s][i]) || (w_cx[1-s][j] >= w_cx[s][(i+1)&3])) &&
                        ((w_cy[1-s][j] <= w_cy[s][i]) || (w_cy[1-s][j] <= w_cy[s][(i+1)&3])) &&
                        ((w_cy[1-s][j] >= w_cy[s][i]) || (w_cy[1-s][j] >= w_cy[s][(i+1)&3]));
                    w_flg.cr[s][i*4+j] =
                        (w_cy[1-s][j] > w_cy[s][i]) != (w_cy[1-s][(j+3)&3] > w_cy[s][i]);
                    w_flg.pos[s][i*4+j] = w_cy[1-s][(j+3)&3] > w_cy[1-s][j];
                end
            end
        end
    end

    // Carry the flags alongside the cross-product stages
    always_ff @(posedge i_clk) begin
        if (w_en[5]) r_flg[0] <= w_flg;
        if (w_en[6]) r_flg[1] <= r_flg[0];
        if (w_en[7]) r_flg[2] <= r_flg[1];
    end

    function automatic t_orient f_orient(input t_xcls c);
        if (c.near_zero) return ORIENT_COLIN;
        else if (c.neg)  return ORIENT_CCW;
        else             return ORIENT_CW;
    endfunction

    // Merge edge meets and corner-inside parities
    always_comb begin
        t_orient o1;
        t_orient o2;
        t_orient o3;
        t_orient o4;
        logic    par;
        logic    up;
        w_hit = 1'b0;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                o1 = f_orient(w_or[0][i*4+j]);
                o2 = f_orient(w_or[0][i*4+((j+1)&3)]);
                o3 = f_orient(w_or[1][j*4+i]);
                o4 = f_orient(w_or[1][j*4+((i+1)&3)]);
                if ((o1 != o2) && (o3 != o4)) w_hit = 1'b1;
                if ((o1 == ORIENT_COLIN) && r_flg[2].box[0][i*4+j]) w_hit = 1'b1;
                if ((o2 == ORIENT_COLIN) && r_flg[2].box[0][i*4+((j+1)&3)]) w_hit = 1'b1;
                if ((o3 == ORIENT_COLIN) && r_flg[2].box[1][j*4+i]) w_hit = 1'b1;
                if ((o4 == ORIENT_COLIN) && r_flg[2].box[1][j*4+((i+1)&3)]) w_hit = 1'b1;
            end
        end
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < 4; i++) begin
                par = 1'b0;
                for (int j = 0; j < 4; j++) begin
                    up = r_flg[2].pos[s][i*4+j] ?
                         (!w_in[s][i*4+j].neg && !w_in[s][i*4+j].zero) :
                         w_in[s][i*4+j].neg;
                    if (r_flg[2].cr[s][i*4+j] && up) par = !par;
                end
                if (par) w_hit = 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_en[8]) r_overlap <= w_hit;
    end

    assign o_m_axis_tvalid = r_v[STAGES-1];
    assign o_m_axis_tdata  = {(OUT_TDATA_W-1)'(0), r_overlap};

endmodule
